@@ rtl/core/b32enc_pkg.sv @@
// Shared types and constants for the Bech32/Bech32m address text encoder.
// Holds the polymod generator, the 32-entry charset and the fold request type.
// No dependencies; every other file in rtl/core but b32enc_chk refers to it by scoped names.
package b32enc_pkg;

    // Field and register widths
    localparam int SYM_W      = 5;
    localparam int CHR_W      = 7;
    localparam int ACC_W      = 30;
    localparam int CNT_W      = 3;
    localparam int LEN_W      = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Default for the largest number of prefix characters
    localparam int MAX_PREFIX_CHARS = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_TEXT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT       = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_PREFIX_TEXT   = 64'h6362;
    localparam logic [LEN_W-1:0]      RST_PREFIX_LENGTH = 4'd2;
    localparam logic                  RST_VARIANT       = 1'b0;

    // Final constants of the two variants and the accumulator start value
    localparam logic [ACC_W-1:0] CONST_BECH32  = 30'h0000_0001;
    localparam logic [ACC_W-1:0] CONST_BECH32M = 30'h2bc8_30a3;
    localparam logic [ACC_W-1:0] ACC_INIT      = 30'h0000_0001;

    // Separator character and the lowercase bit
    localparam logic [CHR_W-1:0] SEP_CHAR  = 7'h31;
    localparam logic [CHR_W-1:0] LOWER_BIT = 7'h20;

    // Index of the last of the six checksum groups
    localparam logic [CNT_W-1:0] CNT_LAST_GROUP = 3'd5;

    // Polymod generator terms, one per bit of the top five accumulator bits
    localparam logic [ACC_W-1:0] GEN_POLY [0:4] = '{
        30'h3b6a_57b2, 30'h2650_8e6d, 30'h1ea1_19fa, 30'h3d42_33dd, 30'h2a14_62b3
    };

    // Charset "qpzry9x8gf2tvdw0s3jn54khce6mua7l" as 7-bit ASCII
    localparam logic [CHR_W-1:0] CHARSET [0:31] = '{
        7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
        7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
        7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
        7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
    };

    // Request to the shared polymod unit
    typedef struct packed {
        logic             init;
        logic             step;
        logic [SYM_W-1:0] value;
    } t_fold_req;

endpackage

@@ rtl/core/b32enc_in_if.sv @@
// Input channel of the encoder: one 5-bit data symbol per transaction.
// Depends on b32enc_pkg for the field widths.
interface b32enc_in_if;
    logic                        valid;
    logic                        ready;
    logic [b32enc_pkg::SYM_W-1:0] symbol;
    logic                        last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

@@ rtl/core/b32enc_out_if.sv @@
// Output channel of the encoder: one ASCII character per transaction.
// Depends on b32enc_pkg for the field widths.
interface b32enc_out_if;
    logic                        valid;
    logic                        ready;
    logic [b32enc_pkg::CHR_W-1:0] character;
    logic                        last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ rtl/core/b32enc_polymod.sv @@
// Shared polymod unit: folds one 5-bit value into the 30-bit checksum per cycle.
// Depends on b32enc_pkg for the generator terms and the request type.
module b32enc_polymod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  b32enc_pkg::t_fold_req         i_req,
    output logic [b32enc_pkg::ACC_W-1:0]  o_acc
);

    logic [b32enc_pkg::ACC_W-1:0] r_acc;
    logic [b32enc_pkg::ACC_W-1:0] n_acc;
    logic [b32enc_pkg::ACC_W-1:0] w_fold;
    logic [4:0]                   w_top;

    // One polymod step: shift in the value, then add the generator terms
    // selected by the five bits shifted out.
    always_comb begin
        w_top  = r_acc[b32enc_pkg::ACC_W-1 -: 5];
        w_fold = {r_acc[b32enc_pkg::ACC_W-6:0], 5'b0_0000}
               ^ {{(b32enc_pkg::ACC_W - b32enc_pkg::SYM_W){1'b0}}, i_req.value};
        for (int j = 0; j < 5; j++) begin
            if (w_top[j]) begin
                w_fold = w_fold ^ b32enc_pkg::GEN_POLY[j];
            end
        end
    end

    // Next accumulator value
    always_comb begin
        n_acc = r_acc;
        if (i_req.init) begin
            n_acc = b32enc_pkg::ACC_INIT;
        end else if (i_req.step) begin
            n_acc = w_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= b32enc_pkg::ACC_INIT;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/core/b32enc_seq.sv @@
// Sequencer of the encoder: steps through the prefix, symbol and checksum
// phases, drives the shared polymod unit and holds the output register.
// Depends on b32enc_pkg and the two channel interfaces.
module b32enc_seq #(
    parameter int MAX_PREFIX_CHARS = b32enc_pkg::MAX_PREFIX_CHARS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    b32enc_in_if.sink                          i_sym,
    b32enc_out_if.source                       o_chr,
    input  logic [b32enc_pkg::CFG_DATA_W-1:0]  i_prefix_text,
    input  logic [b32enc_pkg::LEN_W-1:0]       i_prefix_length,
    input  logic                               i_variant,
    input  logic [b32enc_pkg::ACC_W-1:0]       i_acc,
    output b32enc_pkg::t_fold_req              o_fold
);

    localparam logic [b32enc_pkg::LEN_W-1:0] MAX_LEN = b32enc_pkg::LEN_W'(MAX_PREFIX_CHARS);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PHI   = 4'd1;
    localparam logic [3:0] S_PSEP  = 4'd2;
    localparam logic [3:0] S_PLO   = 4'd3;
    localparam logic [3:0] S_PEMIT = 4'd4;
    localparam logic [3:0] S_SEPCH = 4'd5;
    localparam logic [3:0] S_SYM   = 4'd6;
    localparam logic [3:0] S_PAD   = 4'd7;
    localparam logic [3:0] S_CEMIT = 4'd8;

    logic [3:0]                         r_state, n_state;
    logic [b32enc_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                               r_in_addr, n_in_addr;
    logic [b32enc_pkg::SYM_W-1:0]       r_sym, n_sym;
    logic                               r_last, n_last;
    logic                               r_oval, n_oval;
    logic [b32enc_pkg::CHR_W-1:0]       r_char, n_char;
    logic                               r_lastc, n_lastc;

    logic [b32enc_pkg::LEN_W-1:0]       w_len;
    logic [7:0]                         w_byte;
    logic                               w_len_end;
    logic                               w_can_emit;
    logic [b32enc_pkg::ACC_W-1:0]       w_pm;
    logic [b32enc_pkg::SYM_W-1:0]       w_group;

    // Prefix length saturated to the supported maximum
    assign w_len = (i_prefix_length > MAX_LEN) ? MAX_LEN : i_prefix_length;

    // Prefix byte selected by the counter
    assign w_byte    = i_prefix_text[{r_cnt, 3'b000} +: 8];
    assign w_len_end = ({1'b0, r_cnt} == (w_len - 4'd1));

    // The output register may be loaded when it is empty or being drained
    assign w_can_emit = !r_oval || o_chr.ready;

    // Final checksum with the variant constant, and the group to emit
    assign w_pm = i_acc ^ (i_variant ? b32enc_pkg::CONST_BECH32M : b32enc_pkg::CONST_BECH32);

    always_comb begin
        case (r_cnt)
            3'd0:    w_group = w_pm[29:25];
            3'd1:    w_group = w_pm[24:20];
            3'd2:    w_group = w_pm[19:15];
            3'd3:    w_group = w_pm[14:10];
            3'd4:    w_group = w_pm[9:5];
            default: w_group = w_pm[4:0];
        endcase
    end

    // Next-state logic of the sequencer and the output register
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_in_addr = r_in_addr;
        n_sym     = r_sym;
        n_last    = r_last;
        n_oval    = r_oval && !o_chr.ready;
        n_char    = r_char;
        n_lastc   = r_lastc;
        o_fold    = '{init: 1'b0, step: 1'b0, value: '0};

        case (r_state)
            S_IDLE: begin
                if (i_sym.valid) begin
                    n_sym  = i_sym.symbol;
                    n_last = i_sym.last_symbol;
                    n_cnt  = '0;
                    if (!r_in_addr) begin
                        o_fold.init = 1'b1;
                        n_state = (w_len == '0) ? S_PSEP : S_PHI;
                    end else begin
                        n_state = S_SYM;
                    end
                end
            end
            S_PHI: begin
                o_fold.step  = 1'b1;
                o_fold.value = {2'b00, w_byte[7:5]};
                if (w_len_end) begin
                    n_cnt   = '0;
                    n_state = S_PSEP;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_PSEP: begin
                o_fold.step = 1'b1;
                n_cnt       = '0;
                n_state     = (w_len == '0) ? S_SEPCH : S_PLO;
            end
            S_PLO: begin
                o_fold.step  = 1'b1;
                o_fold.value = w_byte[4:0];
                if (w_len_end) begin
                    n_cnt   = '0;
                    n_state = S_PEMIT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_PEMIT: begin
                if (w_can_emit) begin
                    n_oval  = 1'b1;
                    n_char  = w_byte[6:0] | b32enc_pkg::LOWER_BIT;
                    n_lastc = 1'b0;
                    if (w_len_end) begin
                        n_cnt   = '0;
                        n_state = S_SEPCH;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_SEPCH: begin
                if (w_can_emit) begin
                    n_oval    = 1'b1;
                    n_char    = b32enc_pkg::SEP_CHAR;
                    n_lastc   = 1'b0;
                    n_in_addr = 1'b1;
                    n_state   = S_SYM;
                end
            end
            S_SYM: begin
                if (w_can_emit) begin
                    n_oval       = 1'b1;
                    n_char       = b32enc_pkg::CHARSET[r_sym];
                    n_lastc      = 1'b0;
                    o_fold.step  = 1'b1;
                    o_fold.value = r_sym;
                    n_cnt        = '0;
                    n_state      = r_last ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                o_fold.step = 1'b1;
                if (r_cnt == b32enc_pkg::CNT_LAST_GROUP) begin
                    n_cnt   = '0;
                    n_state = S_CEMIT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_CEMIT: begin
                if (w_can_emit) begin
                    n_oval  = 1'b1;
                    n_char  = b32enc_pkg::CHARSET[w_group];
                    n_lastc = (r_cnt == b32enc_pkg::CNT_LAST_GROUP);
                    if (r_cnt == b32enc_pkg::CNT_LAST_GROUP) begin
                        o_fold.init = 1'b1;
                        n_in_addr   = 1'b0;
                        n_cnt       = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_in_addr <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_in_addr <= n_in_addr;
            r_oval    <= n_oval;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_last  <= n_last;
        r_char  <= n_char;
        r_lastc <= n_lastc;
    end

    assign i_sym.ready     = (r_state == S_IDLE);
    assign o_chr.valid     = r_oval;
    assign o_chr.character = r_char;
    assign o_chr.last_char = r_lastc;

endmodule

@@ rtl/core/bech32_checksum_encoder_top.sv @@
// Top level of the Bech32/Bech32m address text encoder.
// Depends on b32enc_pkg, b32enc_in_if, b32enc_out_if, b32enc_seq and b32enc_polymod.
//
// Usage: data symbols enter on i_sym, one per transaction, with last_symbol set
// on the final symbol of an address. The address text leaves on o_chr, one
// ASCII character per transaction, with last_char set on the final checksum
// character. The prefix text, prefix length and variant are written through
// the configuration port while the block is idle.
// Timing: i_sym.ready is high only while the sequencer waits for a symbol.
// A symbol inside an address is registered on acceptance, and its character
// is then loaded into the output register once that register can take it.
// The first symbol of an address adds 2*L + 1 prefix folds and L + 1
// characters of prefix and separator output, L being the saturated prefix
// length. The last symbol adds 6 padding folds and 6 checksum characters.
// All folds run through the single polymod unit, one a cycle while the output does not stall.
// Reset (synchronous, active low) clears the sequencer, empties the output
// register, sets the checksum to one and restores the default configuration.
// When the receiver stalls, the character is held in the output register and
// the sequencer waits at its next output step.
module bech32_checksum_encoder_top #(
    parameter int MAX_PREFIX_CHARS = b32enc_pkg::MAX_PREFIX_CHARS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    b32enc_in_if.sink                           i_sym,
    b32enc_out_if.source                        o_chr,
    input  logic                                i_cfg_wr_en,
    input  logic [b32enc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [b32enc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [b32enc_pkg::CFG_DATA_W-1:0] r_prefix_text;
    logic [b32enc_pkg::LEN_W-1:0]      r_prefix_length;
    logic                              r_variant;
    logic [b32enc_pkg::ACC_W-1:0]      w_acc;
    b32enc_pkg::t_fold_req             w_fold;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_text   <= b32enc_pkg::RST_PREFIX_TEXT;
            r_prefix_length <= b32enc_pkg::RST_PREFIX_LENGTH;
            r_variant       <= b32enc_pkg::RST_VARIANT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                b32enc_pkg::CFG_PREFIX_TEXT: begin
                    r_prefix_text <= i_cfg_data;
                end
                b32enc_pkg::CFG_PREFIX_LENGTH: begin
                    r_prefix_length <= i_cfg_data[b32enc_pkg::LEN_W-1:0];
                end
                b32enc_pkg::CFG_VARIANT: begin
                    r_variant <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output register
    b32enc_seq #(
        .MAX_PREFIX_CHARS (MAX_PREFIX_CHARS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sym           (i_sym),
        .o_chr           (o_chr),
        .i_prefix_text   (r_prefix_text),
        .i_prefix_length (r_prefix_length),
        .i_variant       (r_variant),
        .i_acc           (w_acc),
        .o_fold          (w_fold)
    );

    // Shared checksum unit
    b32enc_polymod u_polymod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fold),
        .o_acc   (w_acc)
    );

endmodule

@@ rtl/core/b32enc_chk.sv @@
// Port-level checker for the encoder top level, attached by the bind below.
// Depends only on the ports of bech32_checksum_encoder_top.
module b32enc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_last
);

    // A stalled output transaction keeps its character
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
        && $stable(i_out_last))
        else $error("output character changed while stalled");

    // Every accepted symbol keeps the input closed in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input open right after an accepted symbol");

    // The final checksum character appears just as the block becomes free again
    a_last_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid && i_out_last) |-> i_in_ready)
        else $error("final character shown while the block is still busy");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind bech32_checksum_encoder_top b32enc_chk u_b32enc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sym.valid),
    .i_in_ready  (i_sym.ready),
    .i_out_valid (o_chr.valid),
    .i_out_ready (o_chr.ready),
    .i_out_char  (o_chr.character),
    .i_out_last  (o_chr.last_char)
);
